@@ rtl/mtt_pkg.sv @@
// ---------------------------------------------------------------------------
// mtt_pkg
// Shared constants, codes and types for the timer table core.
// ---------------------------------------------------------------------------
package mtt_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIME_BITS  = 32;
	localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int ACT_W      = 3;
	localparam int ID_W       = 4;
	localparam int REP_W      = 16;
	localparam int STS_W      = 3;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [ACT_W-1:0]     action_t;
	typedef logic [STS_W-1:0]     status_t;

	// actions
	localparam action_t ACT_ADD    = 3'd0;
	localparam action_t ACT_REMOVE = 3'd1;
	localparam action_t ACT_MODIFY = 3'd2;
	localparam action_t ACT_SCAN   = 3'd3;
	localparam action_t ACT_QUERY  = 3'd4;

	// result status
	localparam status_t ST_ADDED        = 3'd0;
	localparam status_t ST_DONE         = 3'd1;
	localparam status_t ST_NOT_LIVE     = 3'd2;
	localparam status_t ST_FULL         = 3'd3;
	localparam status_t ST_EXPIRED      = 3'd4;
	localparam status_t ST_NONE_EXPIRED = 3'd5;
	localparam status_t ST_TIMEOUT      = 3'd6;
	localparam status_t ST_NO_LIVE      = 3'd7;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  timer_id;
		time_t            late;
		time_t            timeout;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;   // latch input beat
		logic clr_walk;  // reset walk index and accumulators
		logic exec;      // single-step add/remove/modify, load result
		logic step;      // process one slot of a scan or query
		logic flush;     // load final result of a scan or query
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done;  // current slot is the last one
		logic need_out;   // this step pushes a held result out
		logic held_vld;   // an expired result is held back
	} sts_t;

endpackage

@@ rtl/mtt_ctrl.sv @@
// ---------------------------------------------------------------------------
// mtt_ctrl
// Sequencer for the timer table: accepts a beat, runs it, paces results.
// ---------------------------------------------------------------------------
module mtt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mtt_pkg::action_t in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mtt_pkg::sts_t    sts,
	output mtt_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_WALK  = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;
	logic   out_load;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in  = 1'b1;
					cmd.clr_walk = 1'b1;
					if (in_action == mtt_pkg::ACT_ADD || in_action == mtt_pkg::ACT_REMOVE ||
					    in_action == mtt_pkg::ACT_MODIFY) begin
						state_nxt = S_EXEC;
					end else if (in_action == mtt_pkg::ACT_SCAN ||
					             in_action == mtt_pkg::ACT_QUERY) begin
						state_nxt = S_WALK;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_WALK: begin
				if (!sts.need_out || out_free) begin
					cmd.step = 1'b1;
					if (sts.walk_done) begin
						state_nxt = S_FLUSH;
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					cmd.flush = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign out_load = cmd.exec || cmd.flush || (cmd.step && sts.need_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/mtt_dp.sv @@
// ---------------------------------------------------------------------------
// mtt_dp
// Slot store, walk index, compare/update arithmetic and result register.
// ---------------------------------------------------------------------------
module mtt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mtt_pkg::cmd_t                 cmd,
	input  mtt_pkg::action_t              in_action,
	input  logic [mtt_pkg::ID_W-1:0]      in_slot,
	input  logic [mtt_pkg::REP_W-1:0]     in_repeat,
	input  logic                          in_loop,
	input  mtt_pkg::time_t                in_period,
	input  mtt_pkg::time_t                in_now,
	output mtt_pkg::sts_t                 sts,
	output mtt_pkg::res_t                 out_res,
	output logic                          out_last
);

	localparam int N = mtt_pkg::NUM_TIMERS;

	// latched command
	mtt_pkg::action_t              act_q;
	logic [mtt_pkg::ID_W-1:0]      slot_q;
	logic [mtt_pkg::REP_W-1:0]     rep_q;
	logic                          loop_q;
	mtt_pkg::time_t                per_in_q;
	mtt_pkg::time_t                now_q;

	// slot store
	logic [N-1:0]                  inuse_q;
	logic [N-1:0]                  pend_q;
	mtt_pkg::time_t                dl_q   [N];
	mtt_pkg::time_t                per_q  [N];
	logic [mtt_pkg::REP_W-1:0]     rep_left_q [N];
	logic [N-1:0]                  alw_q;

	// walk
	mtt_pkg::slot_t                idx_q;
	logic                          held_vld_q;
	logic                          found_q;
	mtt_pkg::res_t                 held_q;
	mtt_pkg::time_t                best_q;

	mtt_pkg::res_t                 out_q;
	logic                          out_last_q;

	logic                          free_any;
	mtt_pkg::slot_t                free_idx;
	logic                          tgt_live;
	mtt_pkg::slot_t                tgt;
	mtt_pkg::time_t                cur_dl;
	mtt_pkg::time_t                cur_per;
	logic [mtt_pkg::REP_W-1:0]     cur_rep;
	logic [mtt_pkg::REP_W-1:0]     rep_dec;
	logic                          cur_use;
	logic                          cur_pend;
	logic                          cur_alw;
	logic                          is_scan;
	logic                          exp_hit;
	logic                          q_hit;
	mtt_pkg::time_t                rearm;
	mtt_pkg::time_t                arm_new;
	mtt_pkg::res_t                 exec_res;
	mtt_pkg::res_t                 flush_res;
	mtt_pkg::res_t                 exp_res;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (!inuse_q[i]) begin
				free_any = 1'b1;
				free_idx = mtt_pkg::SLOT_W'(i);
			end
		end
	end

	assign tgt      = slot_q[mtt_pkg::SLOT_W-1:0];
	assign tgt_live = ({1'b0, slot_q} < (mtt_pkg::ID_W + 1)'(N)) && inuse_q[tgt] && !pend_q[tgt];

	assign cur_dl   = dl_q[idx_q];
	assign cur_per  = per_q[idx_q];
	assign cur_rep  = rep_left_q[idx_q];
	assign cur_use  = inuse_q[idx_q];
	assign cur_pend = pend_q[idx_q];
	assign cur_alw  = alw_q[idx_q];
	assign rep_dec  = cur_rep - 1'b1;

	assign is_scan = (act_q == mtt_pkg::ACT_SCAN);
	assign exp_hit = is_scan && cur_use && !cur_pend && (cur_dl <= now_q);
	assign q_hit   = (act_q == mtt_pkg::ACT_QUERY) && cur_use && !cur_pend &&
	                 (!found_q || cur_dl < best_q);

	assign rearm   = now_q + cur_per;
	assign arm_new = now_q + per_in_q;

	always_comb begin
		exec_res = '0;
		if (act_q == mtt_pkg::ACT_ADD) begin
			if (free_any) begin
				exec_res.status   = mtt_pkg::ST_ADDED;
				exec_res.timer_id = mtt_pkg::ID_W'(free_idx);
			end else begin
				exec_res.status = mtt_pkg::ST_FULL;
			end
		end else begin
			exec_res.status = tgt_live ? mtt_pkg::ST_DONE : mtt_pkg::ST_NOT_LIVE;
		end
	end

	always_comb begin
		exp_res          = '0;
		exp_res.status   = mtt_pkg::ST_EXPIRED;
		exp_res.timer_id = mtt_pkg::ID_W'(idx_q);
		exp_res.late     = now_q - cur_dl;
	end

	always_comb begin
		flush_res = '0;
		if (is_scan) begin
			flush_res        = held_q;
			if (!held_vld_q) begin
				flush_res        = '0;
				flush_res.status = mtt_pkg::ST_NONE_EXPIRED;
			end
		end else if (found_q) begin
			flush_res.status  = mtt_pkg::ST_TIMEOUT;
			flush_res.timeout = (best_q <= now_q) ? '0 : (best_q - now_q);
		end else begin
			flush_res.status = mtt_pkg::ST_NO_LIVE;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inuse_q    <= '0;
			pend_q     <= '0;
			idx_q      <= '0;
			held_vld_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (cmd.clr_walk) begin
				idx_q      <= '0;
				held_vld_q <= 1'b0;
				found_q    <= 1'b0;
			end
			if (cmd.exec) begin
				if (act_q == mtt_pkg::ACT_ADD && free_any) begin
					inuse_q[free_idx] <= 1'b1;
					pend_q[free_idx]  <= 1'b0;
				end else if (act_q == mtt_pkg::ACT_REMOVE && tgt_live) begin
					pend_q[tgt] <= 1'b1;
				end
			end
			if (cmd.step) begin
				idx_q <= idx_q + 1'b1;
				if (is_scan && cur_use && cur_pend) begin
					inuse_q[idx_q] <= 1'b0;
					pend_q[idx_q]  <= 1'b0;
				end else if (exp_hit) begin
					held_vld_q <= 1'b1;
					if (!cur_alw && rep_dec == '0) begin
						inuse_q[idx_q] <= 1'b0;
					end
				end
				if (q_hit) begin
					found_q <= 1'b1;
				end
			end
			// held beat has gone to the output register
			if (cmd.flush) begin
				held_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q    <= in_action;
			slot_q   <= in_slot;
			rep_q    <= in_repeat;
			loop_q   <= in_loop;
			per_in_q <= in_period;
			now_q    <= in_now;
		end
		if (cmd.exec) begin
			out_q      <= exec_res;
			out_last_q <= 1'b1;
			if (act_q == mtt_pkg::ACT_ADD && free_any) begin
				dl_q[free_idx]       <= arm_new;
				per_q[free_idx]      <= per_in_q;
				rep_left_q[free_idx] <= (rep_q == '0) ? mtt_pkg::REP_W'(1) : rep_q;
				alw_q[free_idx]      <= loop_q;
			end else if (act_q == mtt_pkg::ACT_MODIFY && tgt_live) begin
				dl_q[tgt]  <= arm_new;
				per_q[tgt] <= per_in_q;
			end
		end
		if (cmd.step) begin
			if (exp_hit) begin
				held_q <= exp_res;
				if (held_vld_q) begin
					out_q      <= held_q;
					out_last_q <= 1'b0;
				end
				if (cur_alw) begin
					dl_q[idx_q] <= rearm;
				end else begin
					rep_left_q[idx_q] <= rep_dec;
					if (rep_dec != '0) begin
						dl_q[idx_q] <= rearm;
					end
				end
			end
			if (q_hit) begin
				best_q <= cur_dl;
			end
		end
		if (cmd.flush) begin
			out_q      <= flush_res;
			out_last_q <= 1'b1;
		end
	end

	assign sts.walk_done = (idx_q == mtt_pkg::SLOT_W'(N - 1));
	assign sts.need_out  = exp_hit && held_vld_q;
	assign sts.held_vld  = held_vld_q;

	assign out_res  = out_q;
	assign out_last = out_last_q;

endmodule

@@ rtl/multi_timer_table_core.sv @@
// ---------------------------------------------------------------------------
// multi_timer_table_core
// Table of 16 software-style timers with add, remove, modify, scan, query.
// ---------------------------------------------------------------------------
// One command beat in, one or more result beats out. The block takes one
// command at a time: s_axis_tready is high only while it is idle. Add,
// remove and modify then run in the execute state, which waits for a free
// output register. Scan and query walk the slot store one slot per cycle,
// but a step that pushes a held result out waits for a free output register;
// they end in the flush state, which loads the final result. A scan emits
// one beat per expired live slot in slot order, with tlast on the final one,
// or a single "none expired" beat; every other command gives exactly one
// beat with tlast set. Actions 5 to 7 are dropped without a result. Removal
// only marks a slot; it is freed by the next scan. Times are 32-bit unsigned
// and wrap; deadlines are compared as plain unsigned values, so a deadline
// that has wrapped past zero looks early. The result beat sits in an output
// register, so a finished result may wait while the next command is taken.
// ---------------------------------------------------------------------------
module multi_timer_table_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[2:0], timer_slot[6:3], repeat_count[22:7], loop_forever[23],
	// period_ms[55:24], now_ms[87:56]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], timer_id[6:3], late_ms[38:7], timeout_ms[70:39], zero pad [71]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	mtt_pkg::cmd_t    cmd;
	mtt_pkg::sts_t    sts;
	mtt_pkg::res_t    res;
	mtt_pkg::action_t in_action;

	assign in_action = s_axis_tdata[2:0];

	// sequencer
	mtt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_action (in_action),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot store and arithmetic
	mtt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_action (in_action),
		.in_slot   (s_axis_tdata[6:3]),
		.in_repeat (s_axis_tdata[22:7]),
		.in_loop   (s_axis_tdata[23]),
		.in_period (s_axis_tdata[55:24]),
		.in_now    (s_axis_tdata[87:56]),
		.sts       (sts),
		.out_res   (res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, res.timeout, res.late, res.timer_id, res.status};

`ifndef SYNTHESIS
	// a held expired result never survives into idle
	a_held_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !sts.held_vld)
		else $error("held result left over while idle");

	// a known command always takes the block out of idle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready &&
		 (in_action == mtt_pkg::ACT_ADD || in_action == mtt_pkg::ACT_REMOVE ||
		  in_action == mtt_pkg::ACT_MODIFY || in_action == mtt_pkg::ACT_SCAN ||
		  in_action == mtt_pkg::ACT_QUERY)) |=> !s_axis_tready)
		else $error("command accepted but block stayed idle");

	// the result register is never reloaded over an untaken beat
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |->
		!(cmd.exec || cmd.flush || (cmd.step && sts.need_out)))
		else $error("result beat overwritten before taken");
`endif

endmodule
